[rtl/plfs_pkg.sv]
// Package for the looping PCM fade sequencer: word types, register indexes,
// opcodes, sequencer states and reset constants.
// No dependencies; every other file of the block imports it.
`default_nettype none

package plfs_pkg;

  localparam int RATE_HZ_DEF    = 44100;
  localparam int FADE_SEC_MAX   = 63;
  localparam int LOOP_COUNT_RST = 2;
  localparam int FADE_SEC_RST   = 8;

  typedef enum logic [1:0] {
    CFG_TOTAL_FRAMES  = 2'd0,
    CFG_RESTART_FRAME = 2'd1,
    CFG_PASS_COUNT    = 2'd2,
    CFG_FADE_SECONDS  = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OP_PLAY = 1'b0,
    OP_SEEK = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_DIV,
    ST_DIV_WAIT,
    ST_DONE
  } st_e;

  typedef struct packed {
    logic               opcode;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic        [31:0] target_frame;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic               sample_valid;
    logic        [31:0] next_frame;
    logic               finished;
    logic               fade_active;
  } out_word_t;

endpackage

`default_nettype wire

[rtl/plfs_div.sv]
// Shared restoring divider of the fade sequencer, one quotient bit per cycle.
// Uses plfs_pkg only by convention; it is a self-contained unsigned divider.
`default_nettype none

module plfs_div
  import plfs_pkg::*;
#(
  parameter int DivN = 38,
  parameter int DivD = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [DivN-1:0] dividend_i,
  input  wire logic [DivD-1:0] divisor_i,
  output logic                 done_o,
  output logic      [DivN-1:0] quotient_o,
  output logic      [DivD-1:0] remainder_o
);

  localparam int CntW = (DivN > 1) ? $clog2(DivN) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(DivN - 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [DivN-1:0] quo_q;
  logic [DivD-1:0] rem_q;
  logic [DivD-1:0] dsr_q;

  logic [DivD:0]   trial;
  logic [DivD:0]   diff;
  logic            fits;

  // The dividend shifts out of quo_q at the top while quotient bits enter below.
  assign trial = {rem_q, quo_q[DivN-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = !diff[DivD];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DivN-2:0], fits};
      rem_q <= fits ? diff[DivD-1:0] : trial[DivD-1:0];
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

[rtl/pcm_loop_fade_sequencer.sv]
// Looping stereo PCM sequencer with linear fade-out; top level and sequencer.
// Plain play and seek words inside the intro go from execute straight to the result.
// A seek into the loop runs one division (DivN = 38 by default).
// A play word during the fade runs one multiply and one division per channel
// on the shared divider; one word at a time.
// Reset is asynchronous: playback ended, registers at their defaults, no result.
`default_nettype none

module pcm_loop_fade_sequencer
  import plfs_pkg::*;
#(
  parameter int RateHz = RATE_HZ_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_word_o
);

  localparam int FadeW = $clog2(FADE_SEC_MAX * RateHz + 1);
  localparam int ProdW = 16 + FadeW;
  localparam int DivN  = (ProdW > 32) ? ProdW : 32;
  localparam int DivD  = 32;

  // Configuration registers.
  logic [31:0]      total_q;
  logic [31:0]      restart_q;
  logic [6:0]       loop_count_q;
  logic [FadeW-1:0] flen_q;

  // Playback state.
  logic [31:0]      pos_q;
  logic [6:0]       loops_q;
  logic             forever_q;
  logic             fade_on_q;
  logic [FadeW-1:0] fpos_q;
  logic             ended_q;

  // Latched word and work registers.
  logic             op_q;
  logic signed [15:0] left_q;
  logic signed [15:0] right_q;
  logic [31:0]      target_q;
  logic [FadeW-1:0] factor_q;
  logic             ch_q;
  logic [ProdW-1:0] prod_q;
  logic             neg_q;
  logic [31:0]      lcl_q;
  logic [15:0]      res_l_q;
  logic [15:0]      res_r_q;
  logic             valid_q;

  logic             out_valid_q;
  out_word_t        out_word_q;

  st_e state_q, state_d;

  logic             has_loop;
  logic             at_end;
  logic [31:0]      loop_len;
  logic [31:0]      past;
  logic             fade_start;
  logic             play_fade;
  logic [FadeW-1:0] play_fpos;
  logic [6:0]       play_loops;
  logic [FadeW:0]   fpos_inc;
  logic             exec_to_mul;
  logic             exec_to_div;
  logic signed [15:0] sample;
  logic [15:0]      mag;
  logic [ProdW-1:0] prod;
  logic [15:0]      qval;
  logic [31:0]      in_fade;
  logic [31:0]      next_frame;
  logic             out_free;

  logic             div_start;
  logic [DivN-1:0]  div_dividend;
  logic [DivD-1:0]  div_divisor;
  logic             div_done;
  logic [DivN-1:0]  div_quo;
  logic [DivD-1:0]  div_rem;

  assign has_loop = restart_q < total_q;
  assign at_end   = pos_q >= total_q;
  assign loop_len = total_q - restart_q;
  assign past     = target_q - restart_q;
  assign in_fade  = past - lcl_q;

  // A wrap on the last finite loop (or with the count already spent) starts the fade.
  always_comb begin
    fade_start = at_end && !fade_on_q && !forever_q && (loops_q <= 7'd1);
    play_fade  = fade_on_q || fade_start;
    play_fpos  = fade_start ? '0 : fpos_q;
    play_loops = loops_q;
    if (at_end && !fade_on_q && !forever_q) begin
      play_loops = (loops_q <= 7'd1) ? 7'd0 : loops_q - 7'd1;
    end
    fpos_inc = {1'b0, play_fpos} + 1'b1;
  end

  assign exec_to_mul = (op_q == OP_PLAY) && !ended_q && !(at_end && !has_loop) &&
                       play_fade && (play_fpos < flen_q);
  assign exec_to_div = (op_q == OP_SEEK) && has_loop && (target_q > restart_q);

  assign sample = ch_q ? right_q : left_q;
  assign mag    = sample[15] ? 16'(-sample) : 16'(sample);
  assign prod   = ProdW'(mag) * ProdW'(factor_q);
  assign qval   = neg_q ? 16'(-div_quo[15:0]) : div_quo[15:0];

  assign next_frame = (!ended_q && at_end && has_loop) ? restart_q : pos_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign div_start    = (state_q == ST_DIV);
  assign div_dividend = (op_q == OP_SEEK) ? DivN'(past) : DivN'(prod_q);
  assign div_divisor  = (op_q == OP_SEEK) ? loop_len : DivD'(flen_q);

  plfs_div #(
    .DivN(DivN),
    .DivD(DivD)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_to_mul) begin
          state_d = ST_MUL;
        end else if (exec_to_div) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_MUL:  state_d = ST_DIV;
      ST_DIV:  state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_d = (op_q == OP_PLAY && !ch_q) ? ST_MUL : ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q      <= '0;
      restart_q    <= '0;
      loop_count_q <= 7'(LOOP_COUNT_RST);
      flen_q       <= FadeW'(FADE_SEC_RST * RateHz);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TOTAL_FRAMES:  total_q      <= cfg_wdata_i;
        CFG_RESTART_FRAME: restart_q    <= cfg_wdata_i;
        CFG_PASS_COUNT:    loop_count_q <= cfg_wdata_i[6:0];
        CFG_FADE_SECONDS:  flen_q       <= FadeW'(32'(cfg_wdata_i[5:0]) * RateHz);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      loops_q   <= '0;
      forever_q <= 1'b0;
      fade_on_q <= 1'b0;
      fpos_q    <= '0;
      ended_q   <= 1'b1;
    end else begin
      unique case (state_q)
        ST_EXEC: begin
          if (op_q == OP_SEEK) begin
            ended_q   <= 1'b0;
            fade_on_q <= 1'b0;
            fpos_q    <= '0;
            forever_q <= (loop_count_q == 7'd0);
            if (!has_loop) begin
              pos_q   <= (target_q < total_q) ? target_q : total_q;
              loops_q <= '0;
            end else if (target_q <= restart_q) begin
              pos_q   <= target_q;
              loops_q <= loop_count_q;
            end else begin
              loops_q <= '0;
            end
          end else if (!ended_q) begin
            if (at_end && !has_loop) begin
              ended_q <= 1'b1;
            end else begin
              pos_q   <= (at_end ? restart_q : pos_q) + 32'd1;
              loops_q <= play_loops;
              if (play_fade) begin
                fade_on_q <= 1'b1;
                if (play_fpos >= flen_q) begin
                  fpos_q  <= play_fpos;
                  ended_q <= 1'b1;
                end else begin
                  fpos_q  <= fpos_inc[FadeW-1:0];
                  ended_q <= (fpos_inc >= {1'b0, flen_q});
                end
              end
            end
          end
        end
        ST_DIV_WAIT: begin
          if (div_done && op_q == OP_SEEK) begin
            pos_q <= restart_q + div_rem;
            if (!forever_q) begin
              if (div_quo >= DivN'(loop_count_q)) begin
                // Past every loop pass: land inside the fade, or at its end.
                fade_on_q <= 1'b1;
                fpos_q    <= (in_fade < 32'(flen_q)) ? FadeW'(in_fade) : flen_q;
                ended_q   <= (in_fade >= 32'(flen_q));
              end else begin
                loops_q <= loop_count_q - div_quo[6:0];
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_q     <= in_word_i.opcode;
          left_q   <= in_word_i.left_sample;
          right_q  <= in_word_i.right_sample;
          target_q <= in_word_i.target_frame;
        end
      end
      ST_EXEC: begin
        lcl_q    <= 32'(39'(loop_count_q) * 39'(loop_len));
        factor_q <= flen_q - play_fpos;
        ch_q     <= 1'b0;
        valid_q  <= (op_q == OP_PLAY) && !ended_q && !(at_end && !has_loop);
        if (op_q == OP_PLAY && !ended_q && !(at_end && !has_loop) && !play_fade) begin
          res_l_q <= left_q;
          res_r_q <= right_q;
        end else begin
          res_l_q <= '0;
          res_r_q <= '0;
        end
      end
      ST_MUL: begin
        prod_q <= prod;
        neg_q  <= sample[15];
      end
      ST_DIV_WAIT: begin
        if (div_done && op_q == OP_PLAY) begin
          if (ch_q) begin
            res_r_q <= qval;
          end else begin
            res_l_q <= qval;
            ch_q    <= 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_word_q.left_out     <= res_l_q;
      out_word_q.right_out    <= res_r_q;
      out_word_q.sample_valid <= valid_q;
      out_word_q.next_frame   <= next_frame;
      out_word_q.finished     <= ended_q;
      out_word_q.fade_active  <= fade_on_q;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_mul_only_in_fade: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |-> fade_on_q && op_q == OP_PLAY)
    else $error("fade multiply entered without an active fade");

  a_no_sample_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_word_q.sample_valid |->
      out_word_q.left_out == 16'sd0 && out_word_q.right_out == 16'sd0)
    else $error("word without a sample carries nonzero audio");

  a_result_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
    else $error("result word raised outside the done state");

endmodule

`default_nettype wire

[test/pcm_loop_fade_sequencer_tb.sv]
// Self-checking testbench for pcm_loop_fade_sequencer: directed and random play and seek
// words, an in-bench playback tracker that predicts every output word, random stalls.
// Depends on plfs_pkg and the sequencer RTL only.
`timescale 1ns / 1ps

module pcm_loop_fade_sequencer_tb;
  import plfs_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_WORDS = 620;

  // Tracks the playback timeline and queues the output word each input word must produce.
  class playback_scoreboard;
    logic [31:0] total;
    logic [31:0] restart;
    logic [6:0]  loop_cnt;
    logic [5:0]  fade_sec;
    logic [31:0] pos;
    logic [6:0]  loops_left;
    bit          forever_loop;
    bit          fading;
    bit          ended;
    logic [21:0] fade_pos;
    out_word_t   awaited_outputs[$];
    int unsigned errors;
    int unsigned words_seen;

    function new();
      total        = '0;
      restart      = '0;
      loop_cnt     = 7'(LOOP_COUNT_RST);
      fade_sec     = 6'(FADE_SEC_RST);
      pos          = '0;
      loops_left   = '0;
      forever_loop = 1'b0;
      fading       = 1'b0;
      ended        = 1'b1;
      fade_pos     = '0;
      errors       = 0;
      words_seen   = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [31:0] data);
      case (idx)
        CFG_TOTAL_FRAMES:  total = data;
        CFG_RESTART_FRAME: restart = data;
        CFG_PASS_COUNT:    loop_cnt = data[6:0];
        CFG_FADE_SECONDS:  fade_sec = data[5:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return awaited_outputs.size();
    endfunction

    function bit has_loop();
      return restart < total;
    endfunction

    function int unsigned fade_frames();
      return int'(fade_sec) * RATE_HZ_DEF;
    endfunction

    // Linear fade gain (flen - fpos) / flen, truncated toward zero.
    function logic [15:0] fade_scale(logic signed [15:0] s, int unsigned flen,
                                     int unsigned fpos);
      int sv;
      longint unsigned mag, num, den, q;
      if (fpos >= flen) return 16'h0000;
      sv  = int'(s);
      mag = 64'((sv < 0) ? -sv : sv);
      num = 64'(flen - fpos);
      den = 64'(flen);
      q   = (mag * num) / den;
      if (sv < 0) q = -q;
      return q[15:0];
    endfunction

    function void seek_timeline(logic [31:0] target);
      longint unsigned loop_len, past, which, in_fade;
      int unsigned flen;
      flen         = fade_frames();
      ended        = 1'b0;
      fading       = 1'b0;
      fade_pos     = '0;
      forever_loop = (loop_cnt == 0);
      if (!has_loop()) begin
        pos        = (target < total) ? target : total;
        loops_left = '0;
        return;
      end
      if (target <= restart) begin
        pos        = target;
        loops_left = forever_loop ? 7'd0 : loop_cnt;
        return;
      end
      loop_len = 64'(total - restart);
      past     = 64'(target - restart);
      which    = past / loop_len;
      pos      = restart + 32'(past % loop_len);
      if (forever_loop) begin
        loops_left = '0;
      end else if (which >= loop_cnt) begin
        in_fade    = past - 64'(loop_cnt) * loop_len;
        fading     = 1'b1;
        fade_pos   = (in_fade < flen) ? in_fade[21:0] : flen[21:0];
        loops_left = '0;
        if (fade_pos >= flen) ended = 1'b1;
      end else begin
        loops_left = loop_cnt - which[6:0];
      end
    endfunction

    function void note_word(in_word_t w);
      out_word_t   e;
      int unsigned flen;
      e = '0;
      if (w.opcode == OP_SEEK) begin
        seek_timeline(w.target_frame);
      end else if (!ended) begin
        if (pos >= total && !has_loop()) begin
          ended = 1'b1;
        end else begin
          if (pos >= total) begin
            // The last finite pass, or a count already at zero, starts the fade.
            if (!fading && !forever_loop) begin
              if (loops_left <= 1) begin
                loops_left = '0;
                fading     = 1'b1;
                fade_pos   = '0;
              end else begin
                loops_left--;
              end
            end
            pos = restart;
          end
          pos++;
          e.sample_valid = 1'b1;
          if (fading) begin
            flen        = fade_frames();
            e.left_out  = fade_scale(w.left_sample, flen, fade_pos);
            e.right_out = fade_scale(w.right_sample, flen, fade_pos);
            if (fade_pos < flen) fade_pos++;
            if (fade_pos >= flen) ended = 1'b1;
          end else begin
            e.left_out  = w.left_sample;
            e.right_out = w.right_sample;
          end
        end
      end
      e.next_frame  = (!ended && pos >= total && has_loop()) ? restart : pos;
      e.finished    = ended;
      e.fade_active = fading;
      awaited_outputs.push_back(e);
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      words_seen++;
      if (awaited_outputs.size() == 0) begin
        errors++;
        if (errors <= 10) $display("output word %0d arrived with none awaited: %h",
                                   words_seen, got);
        return;
      end
      want = awaited_outputs.pop_front();
      if (got.left_out !== want.left_out || got.right_out !== want.right_out ||
          got.sample_valid !== want.sample_valid || got.next_frame !== want.next_frame ||
          got.finished !== want.finished || got.fade_active !== want.fade_active) begin
        errors++;
        if (errors <= 10) begin
          $display("output word %0d mismatch", words_seen);
          $display("  exp L=%0d R=%0d valid=%b next=%h fin=%b fade=%b", want.left_out,
                   want.right_out, want.sample_valid, want.next_frame, want.finished,
                   want.fade_active);
          $display("  got L=%0d R=%0d valid=%b next=%h fin=%b fade=%b", got.left_out,
                   got.right_out, got.sample_valid, got.next_frame, got.finished,
                   got.fade_active);
        end
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  cfg_idx_e    cfg_idx   = CFG_TOTAL_FRAMES;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid  = 1'b0;
  in_word_t    in_word   = '0;
  logic        out_stall = 1'b0;
  wire         in_stall;
  wire         out_valid;
  out_word_t   out_word;

  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;
  int random_words = 0;

  playback_scoreboard sb;

  pcm_loop_fade_sequencer DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_word(in_word);
      if (out_valid && !out_stall) sb.check_word(out_word);
    end
  end

  // Receiver: random stalls, none while idle_on is clear, or one long hold-off when requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (idle_on) begin
        out_stall <= ($urandom_range(99) < 24);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("pcm_loop_fade_sequencer_tb: done, errors");
    $finish;
  end

  task automatic send_word(in_word_t w);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(99) < 24)
      gap = ($urandom_range(19) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_play(logic [15:0] l, logic [15:0] r);
    in_word_t w;
    w.opcode       = OP_PLAY;
    w.left_sample  = l;
    w.right_sample = r;
    w.target_frame = $urandom;
    send_word(w);
  endtask

  task automatic send_seek(logic [31:0] target);
    in_word_t w;
    w.opcode       = OP_SEEK;
    w.left_sample  = 16'($urandom);
    w.right_sample = 16'($urandom);
    w.target_frame = target;
    send_word(w);
  endtask

  // Waits until every awaited output word has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_cfg(logic [31:0] tot, logic [31:0] ls, logic [6:0] lc,
                           logic [5:0] fs);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_TOTAL_FRAMES;
    cfg_wdata <= tot;
    @(posedge clk);
    cfg_idx   <= CFG_RESTART_FRAME;
    cfg_wdata <= ls;
    @(posedge clk);
    cfg_idx   <= CFG_PASS_COUNT;
    cfg_wdata <= {25'd0, lc};
    @(posedge clk);
    cfg_idx   <= CFG_FADE_SECONDS;
    cfg_wdata <= {26'd0, fs};
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(CFG_TOTAL_FRAMES, tot);
    sb.set_reg(CFG_RESTART_FRAME, ls);
    sb.set_reg(CFG_PASS_COUNT, {25'd0, lc});
    sb.set_reg(CFG_FADE_SECONDS, {26'd0, fs});
  endtask

  // Mostly short loops with few passes, so plays wrap and reach the fade quickly;
  // seeks aim at random frames, loop boundaries, the restart frame, the fade and its tail.
  task automatic random_phase(int n_words, bit squeeze);
    logic [31:0] tot, ls;
    logic [6:0] lc;
    logic [5:0] fs;
    longint unsigned span, base, flen, t64;
    drain();
    case ($urandom_range(9))
      0: begin tot = $urandom; ls = $urandom; end
      1: begin tot = 32'hFFFF_FFFF; ls = tot - $urandom_range(1, 8); end
      2: begin tot = $urandom_range(0, 8); ls = $urandom_range(0, 12); end
      default: begin tot = $urandom_range(2, 40); ls = $urandom_range(0, tot - 1); end
    endcase
    case ($urandom_range(5))
      0: lc = 7'd0;
      1: lc = 7'd100;
      2: lc = 7'($urandom_range(0, 100));
      default: lc = 7'($urandom_range(1, 3));
    endcase
    case ($urandom_range(19))
      0: fs = 6'd0;
      1, 2: fs = 6'd1;
      3, 4: fs = 6'd60;
      default: fs = 6'($urandom_range(1, 60));
    endcase
    write_cfg(tot, ls, lc, fs);
    if (squeeze) hold_req = 1'b1;
    span = (ls < tot) ? 64'(tot - ls) : 64'd1;
    base = 64'(ls) + 64'(lc) * span;
    flen = 64'(fs) * 64'(RATE_HZ_DEF);
    for (int i = 0; i < n_words; i++) begin
      if ((i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(99) < 8)) begin
        case ($urandom_range(5))
          0: t64 = 64'($urandom);
          1: t64 = 64'($urandom_range(0, 64));
          2: t64 = 64'(ls) + span * 64'($urandom_range(0, lc + 1)) +
                   64'($urandom_range(0, 2)) - 64'd1;
          3: t64 = base + flen - 64'($urandom_range(0, 3));
          4: t64 = base + 64'($urandom_range(0, 32'(flen)));
          default: t64 = 64'(ls) - 64'($urandom_range(0, 2));
        endcase
        send_seek(t64[31:0]);
      end else begin
        send_play(16'($urandom), 16'($urandom));
      end
    end
    random_words += n_words;
  endtask

  initial begin
    int phase;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Out of reset playback has ended; with no data a seek lands at the end at once.
    send_play(16'h1234, 16'h4321);
    send_seek(32'd5);
    send_play(16'h7FFF, 16'h8000);

    // Zero-length fade: the wrap into the fade mutes and ends playback.
    drain();
    write_cfg(32'd6, 32'd2, 7'd1, 6'd0);
    send_seek(32'd0);
    send_play(16'h7FFF, 16'h8000);
    send_play(16'h8000, 16'h7FFF);
    send_play(16'hFFFF, 16'h0001);
    send_play(16'h0000, 16'hFFFF);
    send_play(16'h5555, 16'hAAAA);
    send_play(16'hAAAA, 16'h5555);
    send_play(16'h7FFF, 16'h8000);
    send_seek(32'd7);

    // Seek two frames before the end of a one second fade, run it out, then replay.
    drain();
    write_cfg(32'd4, 32'd1, 7'd2, 6'd1);
    send_seek(32'd44105);
    send_play(16'h7FFF, 16'h8000);
    send_play(16'h7FFF, 16'h8000);
    send_play(16'h0001, 16'hFFFF);
    send_seek(32'd5);
    send_play(16'h8000, 16'h7FFF);
    send_play(16'h0100, 16'hFF00);
    send_play(16'h8000, 16'h7FFF);

    drain();
    write_cfg(32'hFFFF_FFFF, 32'hFFFF_FFFE, 7'd100, 6'd60);
    send_seek(32'hFFFF_FFFF);
    send_play(16'h7FFF, 16'h7FFF);
    send_play(16'h8000, 16'h8000);
    send_seek(32'd0);

    // Endless looping never fades.
    drain();
    write_cfg(32'd10, 32'd3, 7'd0, 6'd60);
    send_seek(32'd1000);
    send_play(16'h1111, 16'hEEEE);
    send_play(16'hEEEE, 16'h1111);

    phase = 0;
    while (random_words < RANDOM_WORDS) begin
      idle_on = (phase != 9);
      random_phase($urandom_range(15, 35), phase == 4);
      phase++;
    end
    idle_on = 1'b1;

    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("pcm_loop_fade_sequencer_tb: done, clean");
    else
      $display("pcm_loop_fade_sequencer_tb: done, errors");
    $finish;
  end

endmodule
